[rtl/klfp_pkg.sv]
// Shared types, codes and keyword tables for the keyword/length frame parser.
`default_nettype none

package klfp_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int NUM_KEYWORDS        = 5;

    localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd16;
    localparam logic [NUM_KEYWORDS-1:0] ALL_CANDS = {NUM_KEYWORDS{1'b1}};

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    localparam logic [71:0] KW_GREETING_TXT = "GREETING ";
    localparam logic [71:0] KW_MESSAGE_TXT  = " MESSAGE ";
    localparam logic [71:0] KW_STATUS_TXT   = "  STATUS ";
    localparam logic [71:0] KW_PING_TXT     = "    PING ";
    localparam logic [71:0] KW_PONG_TXT     = "    PONG ";

    typedef enum logic [2:0] {
        KIND_GREETING = 3'd0,
        KIND_MESSAGE  = 3'd1,
        KIND_STATUS   = 3'd2,
        KIND_PING     = 3'd3,
        KIND_PONG     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_KEYWORD  = 3'd1,
        ERR_NOT_GREET = 3'd2,
        ERR_TOO_LONG = 3'd3,
        ERR_BAD_LEN  = 3'd4,
        ERR_OVERFLOW = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        PH_AWAIT  = 2'd0,
        PH_READY  = 2'd1,
        PH_CLOSED = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        STG_KEY = 2'd0,
        STG_LEN = 2'd1,
        STG_PAY = 2'd2
    } stage_t;

    // Keyword length, separator included
    function automatic logic [3:0] kw_len(input kind_t kind);
        logic [3:0] len;
        unique case (kind)
            KIND_GREETING: len = 4'd9;
            KIND_MESSAGE:  len = 4'd8;
            KIND_STATUS:   len = 4'd7;
            KIND_PING:     len = 4'd5;
            KIND_PONG:     len = 4'd5;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // Character at position pos of a keyword; texts are right-aligned in 72 bits
    function automatic logic [7:0] kw_char(input kind_t kind, input logic [3:0] pos);
        logic [71:0] txt;
        logic [3:0]  len;
        logic [3:0]  back;
        unique case (kind)
            KIND_GREETING: txt = KW_GREETING_TXT;
            KIND_MESSAGE:  txt = KW_MESSAGE_TXT;
            KIND_STATUS:   txt = KW_STATUS_TXT;
            KIND_PING:     txt = KW_PING_TXT;
            KIND_PONG:     txt = KW_PONG_TXT;
            default:       txt = '0;
        endcase
        len  = kw_len(kind);
        back = len - 4'd1 - pos;
        return txt[{back, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

[rtl/keyword_length_frame_parser_top.sv]
// Top level of the keyword/length frame parser: one-byte-per-cycle deframer.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per
//   transaction. Output channel (out_valid/out_ready) carries one result per
//   input byte: payload byte with its frame kind and last marker, event flags
//   (became_ready, pong_wanted, pong_seen) and the closed/error_code status.
//   Frames look like "KEYWORD SP decimal-length SP payload"; GREETING first.
//   cfg_wr_en/cfg_wr_data write token_limit; write it only while idle.
// Timing:
//   A byte is decoded in the cycle it is accepted and its result appears in
//   the output register on the next cycle. One byte per cycle is sustained
//   while results are taken; the output register is the only stage, so
//   in_ready is high while the register is empty or drained the same cycle.
// Stall:
//   While out_valid is high and out_ready is low, in_ready drops and the held
//   result stays unchanged.
// Reset:
//   rst_n (async, active low) clears the session to awaiting greeting, empties
//   the output register and restores token_limit to 16. A protocol error is
//   sticky: every later byte yields closed=1 with the saved error code.
`default_nettype none

module keyword_length_frame_parser_top
    import klfp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    // output channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            is_payload,
    output logic [2:0]      frame_kind,
    output logic [7:0]      payload_byte,
    output logic            last_of_frame,
    output logic            became_ready,
    output logic            pong_wanted,
    output logic            pong_seen,
    output logic            closed,
    output logic [2:0]      error_code
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [7:0]              token_limit_reg;
    phase_t                  phase_reg, phase_next;
    stage_t                  stage_reg, stage_next;
    logic [7:0]              count_reg, count_next;
    logic [NUM_KEYWORDS-1:0] cands_reg, cands_next;
    kind_t                   kind_reg, kind_next;
    logic [LENGTH_BITS-1:0]  accum_reg, accum_next;
    logic [LENGTH_BITS-1:0]  remain_reg, remain_next;
    err_t                    err_reg, err_next;

    // Result register
    logic       out_valid_reg;
    logic       is_payload_reg,  is_payload_next;
    kind_t      frame_kind_reg,  frame_kind_next;
    logic [7:0] payload_reg,     payload_next;
    logic       last_reg,        last_next;
    logic       ready_ev_reg,    ready_ev_next;
    logic       pong_want_reg,   pong_want_next;
    logic       pong_seen_reg,   pong_seen_next;
    logic       closed_reg,      closed_next;
    err_t       err_out_reg,     err_out_next;

    logic accept;

    // The result register frees up when it is empty or drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------------
    // Per-byte decode helpers
    // ---------------------------------------------------------------
    logic [8:0]              count_inc;
    logic                    too_long;
    logic [NUM_KEYWORDS-1:0] keep;
    logic                    kw_done;
    kind_t                   done_kind;
    logic                    is_space;
    logic                    is_digit;
    logic [LENGTH_BITS+3:0]  accum_x10;
    logic                    len_ovf;
    logic [LENGTH_BITS-1:0]  remain_dec;
    logic                    pay_last;

    assign count_inc = {1'b0, count_reg} + 9'd1;
    assign too_long  = count_inc > {1'b0, token_limit_reg};
    assign is_space  = rx_byte == ASCII_SPACE;
    assign is_digit  = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);

    // Narrow the candidate set by comparing the byte against each keyword
    always_comb
    begin
        keep      = '0;
        kw_done   = 1'b0;
        done_kind = KIND_GREETING;
        for (int i = 0; i < NUM_KEYWORDS; i++)
        begin
            if (cands_reg[i] && ({4'd0, count_reg} < {8'd0, kw_len(kind_t'(3'(i)))})
                && (kw_char(kind_t'(3'(i)), count_reg[3:0]) == rx_byte))
            begin
                keep[i] = 1'b1;
                if (count_inc == {5'd0, kw_len(kind_t'(3'(i)))})
                begin
                    kw_done   = 1'b1;
                    done_kind = kind_t'(3'(i));
                end
            end
        end
    end

    // Decimal accumulate: times ten by shift-and-add, overflow in the top nibble
    assign accum_x10 = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                     + {{LENGTH_BITS{1'b0}}, rx_byte[3:0]};
    assign len_ovf   = |accum_x10[LENGTH_BITS+3:LENGTH_BITS];

    assign remain_dec = (remain_reg != '0)
                      ? remain_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1} : remain_reg;
    assign pay_last   = remain_dec == '0;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        count_next  = count_reg;
        cands_next  = cands_reg;
        kind_next   = kind_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        err_next    = err_reg;

        if (phase_reg != PH_CLOSED)
        begin
            unique case (stage_reg)
                STG_KEY:
                begin
                    if (keep == '0)
                    begin
                        phase_next = PH_CLOSED;
                        err_next   = ERR_KEYWORD;
                    end
                    else if (too_long)
                    begin
                        phase_next = PH_CLOSED;
                        err_next   = ERR_TOO_LONG;
                    end
                    else if (kw_done)
                    begin
                        if (phase_reg == PH_AWAIT && done_kind != KIND_GREETING)
                        begin
                            phase_next = PH_CLOSED;
                            err_next   = ERR_NOT_GREET;
                        end
                        else
                        begin
                            kind_next  = done_kind;
                            stage_next = STG_LEN;
                            cands_next = ALL_CANDS;
                            count_next = '0;
                            accum_next = '0;
                        end
                    end
                    else
                    begin
                        cands_next = keep;
                        count_next = count_inc[7:0];
                    end
                end
                STG_LEN:
                begin
                    if (is_space)
                    begin
                        if (accum_reg == '0)
                        begin
                            phase_next = PH_CLOSED;
                            err_next   = ERR_BAD_LEN;
                        end
                        else if (too_long)
                        begin
                            phase_next = PH_CLOSED;
                            err_next   = ERR_TOO_LONG;
                        end
                        else
                        begin
                            remain_next = accum_reg;
                            stage_next  = STG_PAY;
                            count_next  = '0;
                            accum_next  = '0;
                        end
                    end
                    else if (!is_digit)
                    begin
                        phase_next = PH_CLOSED;
                        err_next   = ERR_BAD_LEN;
                    end
                    else if (len_ovf)
                    begin
                        phase_next = PH_CLOSED;
                        err_next   = ERR_OVERFLOW;
                    end
                    else if (too_long)
                    begin
                        phase_next = PH_CLOSED;
                        err_next   = ERR_TOO_LONG;
                    end
                    else
                    begin
                        accum_next = accum_x10[LENGTH_BITS-1:0];
                        count_next = count_inc[7:0];
                    end
                end
                STG_PAY:
                begin
                    remain_next = remain_dec;
                    if (pay_last)
                    begin
                        if (kind_reg == KIND_GREETING && phase_reg == PH_AWAIT)
                        begin
                            phase_next = PH_READY;
                        end
                        stage_next = STG_KEY;
                        cands_next = ALL_CANDS;
                        count_next = '0;
                        accum_next = '0;
                    end
                end
                default:
                begin
                    stage_next = STG_KEY;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result for the accepted byte
    // ---------------------------------------------------------------
    always_comb
    begin
        is_payload_next = 1'b0;
        frame_kind_next = KIND_GREETING;
        payload_next    = '0;
        last_next       = 1'b0;
        ready_ev_next   = 1'b0;
        pong_want_next  = 1'b0;
        pong_seen_next  = 1'b0;
        closed_next     = 1'b0;
        err_out_next    = ERR_NONE;

        if (phase_next == PH_CLOSED)
        begin
            closed_next  = 1'b1;
            err_out_next = err_next;
        end
        else if (stage_reg == STG_PAY)
        begin
            is_payload_next = 1'b1;
            frame_kind_next = kind_reg;
            payload_next    = rx_byte;
            last_next       = pay_last;
            if (pay_last)
            begin
                if (kind_reg == KIND_GREETING && phase_reg == PH_AWAIT)
                begin
                    ready_ev_next = 1'b1;
                end
                else if (kind_reg == KIND_PING)
                begin
                    pong_want_next = 1'b1;
                end
                else if (kind_reg == KIND_PONG)
                begin
                    pong_seen_next = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_limit_reg <= TOKEN_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            token_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_AWAIT;
            stage_reg  <= STG_KEY;
            count_reg  <= '0;
            cands_reg  <= ALL_CANDS;
            kind_reg   <= KIND_GREETING;
            accum_reg  <= '0;
            remain_reg <= '0;
            err_reg    <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            stage_reg  <= stage_next;
            count_reg  <= count_next;
            cands_reg  <= cands_next;
            kind_reg   <= kind_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

    // Output valid: load on accept, drop when taken without a replacement
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the result register, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_payload_reg <= is_payload_next;
            frame_kind_reg <= frame_kind_next;
            payload_reg    <= payload_next;
            last_reg       <= last_next;
            ready_ev_reg   <= ready_ev_next;
            pong_want_reg  <= pong_want_next;
            pong_seen_reg  <= pong_seen_next;
            closed_reg     <= closed_next;
            err_out_reg    <= err_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_payload    = is_payload_reg;
    assign frame_kind    = frame_kind_reg;
    assign payload_byte  = payload_reg;
    assign last_of_frame = last_reg;
    assign became_ready  = ready_ev_reg;
    assign pong_wanted   = pong_want_reg;
    assign pong_seen     = pong_seen_reg;
    assign closed        = closed_reg;
    assign error_code    = err_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A closed session always carries a saved error code
    a_closed_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CLOSED |-> err_reg != ERR_NONE)
        else $error("closed session without error code");

    // A reported closed result names an error and never passes payload
    a_closed_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && closed |-> error_code != ERR_NONE && !is_payload)
        else $error("closed result malformed");

    // A stalled result blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // Frame events only come with the last payload byte
    a_event_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (became_ready || pong_wanted || pong_seen) |-> last_of_frame)
        else $error("frame event without last payload byte");

    // Once closed, the session stays closed
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CLOSED |=> phase_reg == PH_CLOSED)
        else $error("closed session reopened");

endmodule

`default_nettype wire

[bench/tb_keyword_length_frame_parser_top.sv]
// Self-checking testbench for the keyword/length frame parser top level.
`default_nettype none

module tb_keyword_length_frame_parser_top
    import klfp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Largest frame length the parser accepts before it flags an overflow
    localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEFAULT) - 64'd1;

    // One result as the parser reports it for one accepted byte
    typedef struct packed {
        logic        is_payload;
        kind_t       frame_kind;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic        became_ready;
        logic        pong_wanted;
        logic        pong_seen;
        logic        closed;
        err_t        error_code;
    } frame_result_t;

    // ------------------------------------------------------------------
    // DUT signals. Every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'd0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       is_payload;
    logic [2:0] frame_kind;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       became_ready;
    logic       pong_wanted;
    logic       pong_seen;
    logic       closed;
    logic [2:0] error_code;

    keyword_length_frame_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_payload    (is_payload),
        .frame_kind    (frame_kind),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .became_ready  (became_ready),
        .pong_wanted   (pong_wanted),
        .pong_seen     (pong_seen),
        .closed        (closed),
        .error_code    (error_code)
    );

    // ------------------------------------------------------------------
    // Parser shadow state. Keyword texts are indexed by kind_t value and
    // carry their trailing separator.
    // ------------------------------------------------------------------
    string kw_word [NUM_KEYWORDS] = '{"GREETING ", "MESSAGE ", "STATUS ", "PING ", "PONG "};

    logic [7:0]              token_limit_cfg = TOKEN_LIMIT_RESET;
    phase_t                  sess_phase      = PH_AWAIT;
    stage_t                  stage           = STG_KEY;
    logic [7:0]              tok_count       = 8'd0;
    logic [NUM_KEYWORDS-1:0] cands           = ALL_CANDS;
    kind_t                   cur_kind        = KIND_GREETING;
    logic [23:0]             len_accum       = 24'd0;
    logic [23:0]             bytes_left      = 24'd0;
    err_t                    saved_err       = ERR_NONE;

    frame_result_t expected_results [$];
    frame_result_t want_r;

    int unsigned idle_pct        = 0;
    int unsigned stall_pct       = 0;
    int unsigned bytes_sent      = 0;
    int unsigned frames_sent     = 0;
    int unsigned payload_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned mismatch_count  = 0;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Kill a hung run; the slowest legal run needs a few tens of microseconds
    initial
    begin
        #1_000_000;
        $display("Run limit reached with %0d results outstanding", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Latch the first protocol error; the session stays shut until reset
    function automatic void close_session(input err_t code);
        saved_err  = code;
        sess_phase = PH_CLOSED;
    endfunction

    // Advance the shadow parser by one byte and return the result it owes
    function automatic frame_result_t predict_byte(input logic [7:0] b);
        frame_result_t           r;
        logic [NUM_KEYWORDS-1:0] keep;
        int                      done_kind;
        logic [8:0]              next_count;
        logic [63:0]             value;
        r = '0;
        if (sess_phase != PH_CLOSED)
        begin
            next_count = {1'b0, tok_count} + 9'd1;
            case (stage)
                STG_KEY:
                begin
                    // Narrow the candidate set; a keyword is done on its separator
                    keep      = '0;
                    done_kind = -1;
                    for (int i = 0; i < NUM_KEYWORDS; i++)
                    begin
                        if (cands[i] && tok_count < kw_word[i].len()
                            && kw_word[i][tok_count] == b)
                        begin
                            keep[i] = 1'b1;
                            if (tok_count + 1 == kw_word[i].len())
                                done_kind = i;
                        end
                    end
                    if (keep == '0)
                        close_session(ERR_KEYWORD);
                    else if (next_count > token_limit_cfg)
                        close_session(ERR_TOO_LONG);
                    else if (done_kind >= 0)
                    begin
                        if (sess_phase == PH_AWAIT && done_kind != int'(KIND_GREETING))
                            close_session(ERR_NOT_GREET);
                        else
                        begin
                            cur_kind  = kind_t'(done_kind);
                            stage     = STG_LEN;
                            cands     = ALL_CANDS;
                            tok_count = 8'd0;
                            len_accum = 24'd0;
                        end
                    end
                    else
                    begin
                        cands     = keep;
                        tok_count = next_count[7:0];
                    end
                end
                STG_LEN:
                begin
                    if (b == ASCII_SPACE)
                    begin
                        if (len_accum == 24'd0)
                            close_session(ERR_BAD_LEN);
                        else if (next_count > token_limit_cfg)
                            close_session(ERR_TOO_LONG);
                        else
                        begin
                            bytes_left = len_accum;
                            stage      = STG_PAY;
                            tok_count  = 8'd0;
                            len_accum  = 24'd0;
                        end
                    end
                    else if (b < ASCII_ZERO || b > ASCII_NINE)
                        close_session(ERR_BAD_LEN);
                    else
                    begin
                        // Overflow outranks the token limit on the same digit
                        value = 64'(len_accum) * 64'd10 + 64'(b - ASCII_ZERO);
                        if (value > LEN_MAX)
                            close_session(ERR_OVERFLOW);
                        else if (next_count > token_limit_cfg)
                            close_session(ERR_TOO_LONG);
                        else
                        begin
                            len_accum = value[23:0];
                            tok_count = next_count[7:0];
                        end
                    end
                end
                default:
                begin
                    r.is_payload   = 1'b1;
                    r.frame_kind   = cur_kind;
                    r.payload_byte = b;
                    if (bytes_left != 24'd0)
                        bytes_left = bytes_left - 24'd1;
                    if (bytes_left == 24'd0)
                    begin
                        r.last_of_frame = 1'b1;
                        // A repeat greeting is plain payload and raises nothing
                        if (cur_kind == KIND_GREETING && sess_phase == PH_AWAIT)
                        begin
                            r.became_ready = 1'b1;
                            sess_phase     = PH_READY;
                        end
                        else if (cur_kind == KIND_PING)
                            r.pong_wanted = 1'b1;
                        else if (cur_kind == KIND_PONG)
                            r.pong_seen = 1'b1;
                        stage     = STG_KEY;
                        cands     = ALL_CANDS;
                        tok_count = 8'd0;
                        len_accum = 24'd0;
                    end
                end
            endcase
        end
        // Closed: only the status fields survive, on the erroring byte too
        if (sess_phase == PH_CLOSED)
        begin
            r            = '0;
            r.closed     = 1'b1;
            r.error_code = saved_err;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall out_ready at the phase's rate, check every transaction
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 200)
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // Outputs and handshakes are read right after the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transaction with no byte outstanding", $time);
            end
            else
            begin
                want_r = expected_results.pop_front();
                compare_field("is_payload", 8'(want_r.is_payload), 8'(is_payload));
                compare_field("frame_kind", 8'(want_r.frame_kind), 8'(frame_kind));
                compare_field("payload_byte", want_r.payload_byte, payload_byte);
                compare_field("last_of_frame", 8'(want_r.last_of_frame),
                              8'(last_of_frame));
                compare_field("became_ready", 8'(want_r.became_ready), 8'(became_ready));
                compare_field("pong_wanted", 8'(want_r.pong_wanted), 8'(pong_wanted));
                compare_field("pong_seen", 8'(want_r.pong_seen), 8'(pong_seen));
                compare_field("closed", 8'(want_r.closed), 8'(closed));
                compare_field("error_code", 8'(want_r.error_code), 8'(error_code));
                if (want_r.is_payload)
                    payload_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one byte: idle first at the phase's rate, then hold valid until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Send one complete frame; pad the length token with leading zeros,
    // and fill the payload with a fixed byte or, for a negative fill, random ones
    task automatic send_frame(input kind_t kind, input int unsigned len,
                              input int unsigned zeros, input int fill);
        send_text(kw_word[int'(kind)]);
        repeat (zeros) send_byte(ASCII_ZERO);
        send_text($sformatf("%0d", len));
        send_byte(ASCII_SPACE);
        for (int i = 0; i < len; i++)
            send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
        frames_sent++;
    endtask

    // Well-formed frame of random kind that fits the current token limit
    task automatic send_random_frame();
        kind_t       kind;
        int unsigned len;
        int unsigned room;
        int unsigned zeros;
        string       len_txt;
        kind = kind_t'($urandom_range(0, NUM_KEYWORDS - 1));
        if ($urandom_range(0, 19) == 0)
            len = $urandom_range(17, 300);
        else
            len = $urandom_range(1, 16);
        len_txt = $sformatf("%0d", len);
        room    = token_limit_cfg - len_txt.len() - 1;
        zeros   = 0;
        case ($urandom_range(0, 9))
            0:       zeros = room;
            1, 2:    zeros = $urandom_range(0, room < 4 ? room : 4);
            default: zeros = 0;
        endcase
        send_frame(kind, len, zeros, -1);
    endtask

    // Write token_limit with the parser idle. This is also where the sender
    // holds off until every outstanding result has come back.
    task automatic write_token_limit(input logic [7:0] lim);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        token_limit_cfg  = lim;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Open the session with a one-byte greeting carrying 0xFF
    task automatic test_session_open();
        idle_pct  = 0;
        stall_pct = 0;
        send_frame(KIND_GREETING, 1, 0, 8'hFF);
    endtask

    // Ping then pong, payload bytes at the low end of the range
    task automatic test_ping_pong();
        send_frame(KIND_PING, 1, 0, 8'h00);
        send_frame(KIND_PONG, 1, 0, 8'h01);
    endtask

    // Fill tokens to exactly the limit at the top of the register's range and at nine
    task automatic test_token_limit_extremes();
        write_token_limit(8'd255);
        send_frame(KIND_MESSAGE, 3, 253, -1);
        // Nine is the shortest limit that still lets GREETING through;
        // send a repeat greeting with its length token also at nine bytes
        write_token_limit(8'd9);
        send_frame(KIND_GREETING, 12, 6, -1);
    endtask

    // Random frames under each idle/stall mix, each with a fresh token limit
    task automatic test_idle_mix();
        int unsigned idle_set [4]  = '{0, 54, 0, 30};
        int unsigned stall_set [4] = '{0, 0, 54, 30};
        int unsigned goal;
        for (int p = 0; p < 4; p++)
        begin
            write_token_limit(8'($urandom_range(9, 32)));
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            goal      = bytes_sent + 240;
            while (bytes_sent < goal)
                send_random_frame();
        end
    endtask

    // Break the protocol once, then confirm the block stays closed. Which error
    // is driven depends on the seed. Wrong-first-frame can only occur before
    // the greeting, so a single-reset run never reaches it.
    task automatic test_sticky_error();
        kind_t       kind;
        int          k;
        int unsigned lim;
        logic [7:0]  b;
        idle_pct  = 30;
        stall_pct = 30;
        kind = kind_t'($urandom_range(0, NUM_KEYWORDS - 1));
        case ($urandom_range(0, 3))
            0:
            begin
                // Keyword prefix, then a byte that breaks it
                k = $urandom_range(0, kw_word[int'(kind)].len() - 1);
                send_text(kw_word[int'(kind)].substr(0, k - 1));
                do b = 8'($urandom_range(0, 255)); while (b == kw_word[int'(kind)][k]);
                send_byte(b);
            end
            1:
            begin
                // Limits shorter than the keyword fail there; the others in the length
                lim = $urandom_range(0, 1) ? 1 : $urandom_range(2, 12);
                write_token_limit(8'(lim));
                send_text(kw_word[int'(kind)]);
                repeat (lim + 1) send_byte(ASCII_ZERO);
            end
            2:
            begin
                send_text(kw_word[int'(kind)]);
                case ($urandom_range(0, 3))
                    0: send_byte(ASCII_SPACE);
                    1: send_text("0 ");
                    2: send_text("000 ");
                    default:
                    begin
                        send_text("12");
                        do b = 8'($urandom_range(0, 255));
                        while ((b >= ASCII_ZERO && b <= ASCII_NINE) || b == ASCII_SPACE);
                        send_byte(b);
                    end
                endcase
            end
            default:
            begin
                send_text(kw_word[int'(kind)]);
                send_text($urandom_range(0, 1) ? "16777216" : "99999999");
            end
        endcase
        // Anything after this must read back closed with the saved code
        repeat (24) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_session_open();
        test_ping_pong();
        test_token_limit_extremes();
        test_idle_mix();
        test_sticky_error();

        // Drop valid, drain, then give a stray result time to show up
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Parsed %0d bytes in %0d frames (%0d payload bytes) across %0d limit writes",
                 bytes_sent, frames_sent, payload_checked, cfg_writes);
        $display("Mixed sender/receiver stalls; session finally closed with error %0d",
                 saved_err);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/klfp_pkg.sv
rtl/keyword_length_frame_parser_top.sv
bench/tb_keyword_length_frame_parser_top.sv
